FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define BFBS_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) \
		else $error("%m: property failed");
// condition must never be seen outside reset
`define BFBS_NEVER(lbl, ck, rstn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define BFBS_ASSERT(lbl, ck, rstn, prop)
`define BFBS_NEVER(lbl, ck, rstn, cond)
`endif

`endif

FILE: rtl/bfbs_pkg.sv
// ----------------------------------------------------------------------------
// bfbs_pkg
// Shared types, codes, hash constants and the Pearson table.
// ----------------------------------------------------------------------------
package bfbs_pkg;

	localparam logic [1:0] MODE_CHECK  = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_CSET   = 2'd2;

	localparam logic [1:0] CFG_HSEL    = 2'd0;
	localparam logic [1:0] CFG_NPROBES = 2'd1;
	localparam logic [1:0] CFG_FSIZE   = 2'd2;

	localparam logic [63:0] MUR_C1 = 64'h87c37b91114253d5;
	localparam logic [63:0] MUR_C2 = 64'h4cf5ad432745937f;
	localparam logic [63:0] FMIX_1 = 64'h0000_0000_85ebca6b;
	localparam logic [63:0] FMIX_2 = 64'h0000_0000_c2b2ae35;
	localparam logic [63:0] H1_ADD = 64'h0000_0000_52dce729;
	localparam logic [63:0] H2_ADD = 64'h0000_0000_38495ab5;

	localparam int QDEPTH = 2;

	typedef struct packed {
		logic        hsel;
		logic [4:0]  k;
		logic [16:0] size;
	} cfg_t;

	typedef struct packed {
		logic [16:0] p0;
		logic [16:0] p1;
		logic [16:0] size;
		logic [1:0]  mode;
		logic [4:0]  k;
	} req_t;

	typedef enum logic [4:0] {
		F_IDLE, F_K1C1, F_K1C2, F_H1A, F_H1B, F_K2C2, F_K2C1, F_H2A, F_H2B,
		F_FIN, F_FA, F_FB, F_X1, F_X2, F_FC, F_FD, F_JEN,
		F_RGO1, F_RW1, F_RGO2, F_RW2, F_PUSH
	} fstate_t;

	typedef enum logic [3:0] {
		B_CLEAR, B_IDLE, B_MUL, B_RGO, B_RW, B_RA, B_RD, B_WR, B_OUT
	} bstate_t;

	localparam logic [7:0] PEARSON_TAB [256] = '{
		8'd98,8'd6,8'd85,8'd150,8'd36,8'd23,8'd112,8'd164,
		8'd135,8'd207,8'd169,8'd5,8'd26,8'd64,8'd165,8'd219,
		8'd61,8'd20,8'd68,8'd89,8'd130,8'd63,8'd52,8'd102,
		8'd24,8'd229,8'd132,8'd245,8'd80,8'd216,8'd195,8'd115,
		8'd90,8'd168,8'd156,8'd203,8'd177,8'd120,8'd2,8'd190,
		8'd188,8'd7,8'd100,8'd185,8'd174,8'd243,8'd162,8'd10,
		8'd237,8'd18,8'd253,8'd225,8'd8,8'd208,8'd172,8'd244,
		8'd255,8'd126,8'd101,8'd79,8'd145,8'd235,8'd228,8'd121,
		8'd123,8'd251,8'd67,8'd250,8'd161,8'd0,8'd107,8'd97,
		8'd241,8'd111,8'd181,8'd82,8'd249,8'd33,8'd69,8'd55,
		8'd59,8'd153,8'd29,8'd9,8'd213,8'd167,8'd84,8'd93,
		8'd30,8'd46,8'd94,8'd75,8'd151,8'd114,8'd73,8'd222,
		8'd197,8'd96,8'd210,8'd45,8'd16,8'd227,8'd248,8'd202,
		8'd51,8'd152,8'd252,8'd125,8'd81,8'd206,8'd215,8'd186,
		8'd39,8'd158,8'd178,8'd187,8'd131,8'd136,8'd1,8'd49,
		8'd50,8'd17,8'd141,8'd91,8'd47,8'd129,8'd60,8'd99,
		8'd154,8'd35,8'd86,8'd171,8'd105,8'd34,8'd38,8'd200,
		8'd147,8'd58,8'd77,8'd118,8'd173,8'd246,8'd76,8'd254,
		8'd133,8'd232,8'd196,8'd144,8'd198,8'd124,8'd53,8'd4,
		8'd108,8'd74,8'd223,8'd234,8'd134,8'd230,8'd157,8'd139,
		8'd189,8'd205,8'd199,8'd128,8'd176,8'd19,8'd211,8'd236,
		8'd127,8'd192,8'd231,8'd70,8'd233,8'd88,8'd146,8'd44,
		8'd183,8'd201,8'd22,8'd83,8'd13,8'd214,8'd116,8'd109,
		8'd159,8'd32,8'd95,8'd226,8'd140,8'd220,8'd57,8'd12,
		8'd221,8'd31,8'd209,8'd182,8'd143,8'd92,8'd149,8'd184,
		8'd148,8'd62,8'd113,8'd65,8'd37,8'd27,8'd106,8'd166,
		8'd3,8'd14,8'd204,8'd72,8'd21,8'd41,8'd56,8'd66,
		8'd28,8'd193,8'd40,8'd217,8'd25,8'd54,8'd179,8'd117,
		8'd238,8'd87,8'd240,8'd155,8'd180,8'd170,8'd242,8'd212,
		8'd191,8'd163,8'd78,8'd218,8'd137,8'd194,8'd175,8'd110,
		8'd43,8'd119,8'd224,8'd71,8'd122,8'd142,8'd42,8'd160,
		8'd104,8'd48,8'd247,8'd103,8'd15,8'd11,8'd138,8'd239
	};

	function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned s);
		return (v << s) | (v >> (64 - s));
	endfunction

	// keep the low n bytes of a little-endian word (n up to 8)
	function automatic logic [63:0] mask_le(input logic [63:0] w, input logic [3:0] n);
		logic [63:0] r;
		r = '0;
		for (int j = 0; j < 8; j++) begin
			if (4'(j) < n) r[j*8 +: 8] = w[j*8 +: 8];
		end
		return r;
	endfunction

endpackage

FILE: rtl/bfbs_modred.sv
// ----------------------------------------------------------------------------
// bfbs_modred
// Bit-serial remainder of a 64-bit value by a 17-bit modulus.
// ----------------------------------------------------------------------------
module bfbs_modred (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] dividend,
	input  logic [16:0] divisor,
	output logic        done,
	output logic [16:0] rem
);
	localparam int NUM_W = 64;
	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] num_q;
	logic [16:0]      rem_q;
	logic [16:0]      dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [17:0]      trial;
	logic [17:0]      diff;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= num_q << 1;
			rem_q <= (trial >= {1'b0, dvs_q}) ? diff[16:0] : trial[16:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/bfbs_front.sv
// ----------------------------------------------------------------------------
// bfbs_front
// Takes key bytes, runs both hash families, finalizes and reduces positions.
// ----------------------------------------------------------------------------
module bfbs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [1:0]           mode,
	input  logic [7:0]           data_byte,
	input  logic                 has_byte,
	input  logic                 last,
	input  bfbs_pkg::cfg_t       cfg,
	input  logic                 q_full,
	output logic                 push,
	output bfbs_pkg::req_t       push_req,
	output logic                 idle
);
	import bfbs_pkg::*;

	fstate_t state_q, state_d;

	logic [31:0]  jen_q;
	logic [7:0]   pear_q;
	logic [63:0]  h1_q, h2_q;
	logic [127:0] buf_q;
	logic [31:0]  cnt_q;
	logic         fin_q, tail_q, which_q;
	logic [1:0]   ph_q;

	logic [63:0]  ma_q, acc_q;
	logic [16:0]  p0_q, p1_q;
	logic [1:0]   mode_q;
	cfg_t         cfg_q;

	// byte path
	logic [31:0]  j0, j1, j2, cnt_inc;
	logic [7:0]   pear_n;
	logic [127:0] buf_n;
	logic         blk_full;

	// finalize helpers
	logic [31:0]  ja, jb, jc, mag;
	logic [3:0]   tail;
	logic [63:0]  k1tail, k2tail, c64;

	// shared 32x32 multiplier
	logic         mul_st, mdone;
	logic [63:0]  mc, prod, acc_n, fm;
	logic [31:0]  mx, my;

	logic         red_go, red_done;
	logic [63:0]  red_num;
	logic [16:0]  red_rem;

	always_comb begin
		j0       = jen_q + {24'b0, data_byte};
		j1       = j0 + (j0 << 10);
		j2       = j1 ^ 32'($signed(j1) >>> 6);
		pear_n   = PEARSON_TAB[pear_q ^ data_byte];
		cnt_inc  = cnt_q + 32'd1;
		buf_n    = buf_q;
		buf_n[{cnt_q[3:0], 3'b000} +: 8] = data_byte;
		blk_full = has_byte && (cnt_inc[3:0] == 4'd0);
	end

	always_comb begin
		ja     = jen_q + (jen_q << 3);
		jb     = ja ^ 32'($signed(ja) >>> 11);
		jc     = jb + (jb << 15);
		mag    = jc[31] ? (~jc + 32'd1) : jc;
		tail   = cnt_q[3:0];
		k2tail = mask_le(buf_q[127:64], tail - 4'd8);
		k1tail = mask_le(buf_q[63:0], (tail > 4'd8) ? 4'd8 : tail);
		c64    = {32'b0, cnt_q};
	end

	// 64x64 mod 2^64 in three partial products
	always_comb begin
		mx    = (ph_q == 2'd1) ? ma_q[63:32] : ma_q[31:0];
		my    = (ph_q == 2'd2) ? mc[63:32] : mc[31:0];
		prod  = {32'b0, mx} * {32'b0, my};
		acc_n = (ph_q == 2'd0) ? prod : acc_q + {prod[31:0], 32'b0};
		mdone = mul_st && (ph_q == 2'd2);
		fm    = acc_n ^ (acc_n >> 16);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (take) begin
					if (blk_full) state_d = F_K1C1;
					else if (last) state_d = F_FIN;
				end
			end
			F_K1C1: if (mdone) state_d = F_K1C2;
			F_K1C2: if (mdone) state_d = tail_q ? F_FA : F_H1A;
			F_H1A:  state_d = F_H1B;
			F_H1B:  state_d = F_K2C2;
			F_K2C2: if (mdone) state_d = F_K2C1;
			F_K2C1: if (mdone) state_d = tail_q ? F_K1C1 : F_H2A;
			F_H2A:  state_d = F_H2B;
			F_H2B:  state_d = fin_q ? F_FIN : F_IDLE;
			F_FIN: begin
				if (!cfg_q.hsel) state_d = F_JEN;
				else if (tail > 4'd8) state_d = F_K2C2;
				else if (tail != 4'd0) state_d = F_K1C1;
				else state_d = F_FA;
			end
			F_FA:   state_d = F_FB;
			F_FB:   state_d = F_X1;
			F_X1:   if (mdone) state_d = F_X2;
			F_X2:   if (mdone) state_d = which_q ? F_FC : F_X1;
			F_FC:   state_d = F_FD;
			F_FD:   state_d = F_RGO1;
			F_JEN:  state_d = F_RGO1;
			F_RGO1: state_d = F_RW1;
			F_RW1:  if (red_done) state_d = F_RGO2;
			F_RGO2: state_d = F_RW2;
			F_RW2:  if (red_done) state_d = F_PUSH;
			F_PUSH: if (!q_full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		mul_st = 1'b0;
		mc     = '0;
		red_go = 1'b0;
		push   = 1'b0;
		case (state_q)
			F_K1C1, F_K2C1: begin
				mul_st = 1'b1;
				mc     = MUR_C1;
			end
			F_K1C2, F_K2C2: begin
				mul_st = 1'b1;
				mc     = MUR_C2;
			end
			F_X1: begin
				mul_st = 1'b1;
				mc     = FMIX_1;
			end
			F_X2: begin
				mul_st = 1'b1;
				mc     = FMIX_2;
			end
			F_RGO1, F_RGO2: red_go = 1'b1;
			F_PUSH: push = !q_full;
			default: ;
		endcase
	end

	assign red_num = (state_q == F_RGO1) ? h1_q : h2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			jen_q   <= '0;
			pear_q  <= '0;
			h1_q    <= '0;
			h2_q    <= '0;
			buf_q   <= '0;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
			tail_q  <= 1'b0;
			which_q <= 1'b0;
			ph_q    <= '0;
		end else begin
			state_q <= state_d;
			if (mul_st) ph_q <= mdone ? 2'd0 : ph_q + 2'd1;
			else ph_q <= '0;
			case (state_q)
				F_IDLE: begin
					if (take) begin
						fin_q  <= last;
						tail_q <= 1'b0;
						if (has_byte) begin
							jen_q  <= j2;
							pear_q <= pear_n;
							buf_q  <= buf_n;
							cnt_q  <= cnt_inc;
						end
					end
				end
				F_K1C2: if (mdone) h1_q <= h1_q ^ acc_n;
				F_H1A:  h1_q <= rotl64(h1_q, 27) + h2_q;
				F_H1B:  h1_q <= (h1_q << 2) + h1_q + H1_ADD;
				F_K2C1: if (mdone) h2_q <= h2_q ^ acc_n;
				F_H2A:  h2_q <= rotl64(h2_q, 31) + h1_q;
				F_H2B:  h2_q <= (h2_q << 2) + h2_q + H2_ADD;
				F_FIN:  tail_q <= 1'b1;
				F_FA: begin
					h1_q <= (h1_q ^ c64) + (h2_q ^ c64);
					h2_q <= h2_q ^ c64;
				end
				F_FB: begin
					h2_q    <= h2_q + h1_q;
					which_q <= 1'b0;
				end
				F_X2: begin
					if (mdone) begin
						if (!which_q) h1_q <= fm;
						else h2_q <= fm;
						which_q <= 1'b1;
					end
				end
				F_FC:   h1_q <= h1_q + h2_q;
				F_FD:   h2_q <= h2_q + h1_q;
				F_JEN: begin
					h1_q <= {32'b0, mag};
					h2_q <= {56'b0, pear_q};
				end
				F_PUSH: begin
					if (!q_full) begin
						jen_q  <= '0;
						pear_q <= '0;
						h1_q   <= '0;
						h2_q   <= '0;
						cnt_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_st) acc_q <= acc_n;
		case (state_q)
			F_IDLE: begin
				if (take) begin
					if (has_byte) ma_q <= buf_n[63:0];
					if (last) begin
						mode_q <= mode;
						cfg_q  <= cfg;
					end
				end
			end
			F_K1C1: if (mdone) ma_q <= rotl64(acc_n, 31);
			F_H1B:  ma_q <= buf_q[127:64];
			F_K2C2: if (mdone) ma_q <= rotl64(acc_n, 33);
			F_K2C1: if (mdone && tail_q) ma_q <= k1tail;
			F_FIN:  ma_q <= (tail > 4'd8) ? k2tail : k1tail;
			F_FB:   ma_q <= h1_q ^ (h1_q >> 16);
			F_X1:   if (mdone) ma_q <= acc_n ^ (acc_n >> 13);
			F_X2:   if (mdone && !which_q) ma_q <= h2_q ^ (h2_q >> 16);
			F_RW1:  if (red_done) p0_q <= red_rem;
			F_RW2:  if (red_done) p1_q <= red_rem;
			default: ;
		endcase
	end

	bfbs_modred u_red (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (red_go),
		.dividend (red_num),
		.divisor  (cfg_q.size),
		.done     (red_done),
		.rem      (red_rem)
	);

	always_comb begin
		push_req.p0   = p0_q;
		push_req.p1   = p1_q;
		push_req.size = cfg_q.size;
		push_req.mode = mode_q;
		push_req.k    = cfg_q.k;
	end

	assign idle = (state_q == F_IDLE);

endmodule

FILE: rtl/bfbs_queue.sv
// ----------------------------------------------------------------------------
// bfbs_queue
// Two-entry request queue between hashing front and filter back.
// ----------------------------------------------------------------------------
module bfbs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bfbs_pkg::req_t push_req,
	input  logic           pop,
	output bfbs_pkg::req_t head,
	output logic           full,
	output logic           empty
);
	import bfbs_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	req_t            ent_q [QDEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_req;
	end

	assign head  = ent_q[rp_q];
	assign full  = (cnt_q == (PW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);

endmodule

FILE: rtl/bfbs_back.sv
// ----------------------------------------------------------------------------
// bfbs_back
// Owns the bit store: clearing sweep, probe generation, read and set passes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfbs_back #(
	parameter int FILTER_BITS = 65536
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  bfbs_pkg::req_t head,
	output logic           pop,
	output logic           clearing,
	output logic           done,
	output logic           found
);
	import bfbs_pkg::*;

	localparam int AW = $clog2(FILTER_BITS);

	bstate_t     state_q, state_d;
	req_t        req_q;
	logic [33:0] prod_q;
	logic [16:0] q_q, run_q;
	logic [4:0]  idx_q;
	logic        all_q;
	logic [AW-1:0] clr_q;

	logic        mem_q [FILTER_BITS];
	logic        rd_q;

	logic [16:0] pos, run_n;
	logic [17:0] sum;
	logic [AW-1:0] addr;
	logic        we, wdat, last_probe, do_set;
	logic        red_go, red_done;
	logic [16:0] red_rem;

	// next multiple of q, kept below the modulus
	always_comb begin
		sum   = {1'b0, (idx_q == 5'd1) ? q_q : run_q} + {1'b0, q_q};
		run_n = (sum >= {1'b0, req_q.size}) ? 17'(sum - {1'b0, req_q.size}) : sum[16:0];
		if (idx_q == 5'd0) pos = req_q.p0;
		else if (idx_q == 5'd1) pos = req_q.p1;
		else pos = run_q;
		last_probe = (5'(idx_q + 5'd1) == req_q.k);
		do_set = (req_q.mode == MODE_INSERT) || (req_q.mode == MODE_CSET);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR: if (clr_q == AW'(FILTER_BITS - 1)) state_d = B_IDLE;
			B_IDLE:  if (!empty) state_d = B_MUL;
			B_MUL:   state_d = B_RGO;
			B_RGO:   state_d = B_RW;
			B_RW:    if (red_done) state_d = B_RA;
			B_RA:    state_d = B_RD;
			B_RD: begin
				if (!last_probe) state_d = B_RA;
				else if (do_set) state_d = B_WR;
				else state_d = B_OUT;
			end
			B_WR:    if (last_probe) state_d = B_OUT;
			B_OUT:   state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		red_go   = 1'b0;
		we       = 1'b0;
		wdat     = 1'b0;
		addr     = AW'(pos);
		clearing = 1'b0;
		done     = 1'b0;
		case (state_q)
			B_CLEAR: begin
				clearing = 1'b1;
				we       = 1'b1;
				addr     = clr_q;
			end
			B_IDLE: pop = !empty;
			B_RGO:  red_go = 1'b1;
			B_WR: begin
				we   = 1'b1;
				wdat = 1'b1;
			end
			B_OUT:  done = 1'b1;
			default: ;
		endcase
		found = done && (req_q.mode != MODE_INSERT) && all_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				B_CLEAR: clr_q <= clr_q + 1'b1;
				B_RW:    idx_q <= '0;
				B_RD:    idx_q <= (last_probe) ? 5'd0 : idx_q + 5'd1;
				B_WR:    idx_q <= idx_q + 5'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: if (!empty) req_q <= head;
			B_MUL:  prod_q <= {17'b0, req_q.p0} * {17'b0, req_q.p1};
			B_RW: begin
				if (red_done) q_q <= red_rem;
				all_q <= 1'b1;
			end
			B_RD: begin
				all_q <= all_q & rd_q;
				if (idx_q != 5'd0) run_q <= run_n;
			end
			B_WR:   if (idx_q != 5'd0) run_q <= run_n;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdat;
		rd_q <= mem_q[addr];
	end

	bfbs_modred u_red (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (red_go),
		.dividend ({30'b0, prod_q}),
		.divisor  (req_q.size),
		.done     (red_done),
		.rem      (red_rem)
	);

	`BFBS_ASSERT(a_done_single, clk, arst_n, done |=> !done)
	`BFBS_NEVER(a_idx_range, clk, arst_n, (state_q == B_RA || state_q == B_WR) && (idx_q >= req_q.k))
	`BFBS_ASSERT(a_run_range, clk, arst_n, (state_q == B_RA && idx_q >= 5'd2) |-> (run_q < req_q.size))

endmodule

FILE: rtl/bloom_filter_byte_stream.sv
// ----------------------------------------------------------------------------
// bloom_filter_byte_stream
// Bloom filter over byte-stream keys with Jenkins/Pearson or Murmur3-style hashing.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------
//  key item  | start & !busy        | mode, data_byte, has_byte, last
//  result    | done (1-cycle pulse) | found
//  config    | wr_en                | wr_index, wr_data
//
//  A key byte is taken when start is high and busy is low; every 16th byte
//  adds a block mix on the shared 32x32 multiplier. After the last item the
//  front finalizes the selected hash and reduces both positions with two
//  remainders. The back then reads every probe, and writes it on a set.
//  After reset all FILTER_BITS bits are swept clear, with busy high.
//  The result pulse cannot be stalled; the queue decouples front and back.
// ----------------------------------------------------------------------------
module bloom_filter_byte_stream #(
	parameter int FILTER_BITS = 65536,
	parameter int MAX_PROBES  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last,
	output logic        done,
	output logic        found,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [16:0] wr_data
);
	import bfbs_pkg::*;

	// clamp limits for out-of-range register values
	localparam int SIZE_CAP = (FILTER_BITS > 131071) ? 131071 : FILTER_BITS;
	localparam int K_CAP    = (MAX_PROBES > 31) ? 31 : MAX_PROBES;

	logic        hsel_q;
	logic [4:0]  nprobes_q;
	logic [16:0] fsize_q;

	cfg_t        cfg;
	req_t        push_req, head;
	logic        take, push, pop, q_full, q_empty, fe_idle, clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsel_q    <= 1'b1;
			nprobes_q <= 5'd3;
			fsize_q   <= 17'h10000;
		end else if (wr_en) begin
			case (wr_index)
				CFG_HSEL:    hsel_q    <= wr_data[0];
				CFG_NPROBES: nprobes_q <= wr_data[4:0];
				CFG_FSIZE:   fsize_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// effective size and probe count
	always_comb begin
		cfg.hsel = hsel_q;
		if (fsize_q == 17'd0) cfg.size = 17'd1;
		else if (fsize_q > 17'(SIZE_CAP)) cfg.size = 17'(SIZE_CAP);
		else cfg.size = fsize_q;
		if (nprobes_q == 5'd0) cfg.k = 5'd1;
		else if (nprobes_q > 5'(K_CAP)) cfg.k = 5'(K_CAP);
		else cfg.k = nprobes_q;
	end

	// front waits in its own states; store sweep also holds off new items
	assign busy = !fe_idle || clearing;
	assign take = start && !busy;

	bfbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.mode      (mode),
		.data_byte (data_byte),
		.has_byte  (has_byte),
		.last      (last),
		.cfg       (cfg),
		.q_full    (q_full),
		.push      (push),
		.push_req  (push_req),
		.idle      (fe_idle)
	);

	bfbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	bfbs_back #(
		.FILTER_BITS (FILTER_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.head     (head),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.found    (found)
	);

endmodule
